// ----- hw/rtl/sgrenc_pkg.sv -----
// Shared types, character constants and decimal helpers for the SGR encoder.
`default_nettype none

package sgrenc_pkg;

    localparam int          APB_ADDR_W   = 3;
    localparam int          APB_DATA_W   = 32;
    localparam logic [0:0]  REG_NCV_MASK = 1'b0;

    localparam logic [1:0]  KIND_DEFAULT = 2'd0;
    localparam logic [1:0]  KIND_INDEX   = 2'd1;
    localparam logic [1:0]  KIND_RGB     = 2'd2;
    localparam logic [1:0]  KIND_KEEP    = 2'd3;

    localparam logic [7:0]  CH_ESC  = 8'h1B;
    localparam logic [7:0]  CH_BRK  = "[";
    localparam logic [7:0]  CH_SEP  = ";";
    localparam logic [7:0]  CH_END  = "m";
    localparam logic [7:0]  CH_ZERO = "0";
    localparam logic [7:0]  CH_ONE  = "1";
    localparam logic [7:0]  CH_TWO  = "2";
    localparam logic [7:0]  CH_FIVE = "5";
    localparam logic [7:0]  CH_EIGHT = "8";
    localparam logic [7:0]  CH_NINE = "9";
    localparam logic [7:0]  CH_FG_LEAD = "3";
    localparam logic [7:0]  CH_BG_LEAD = "4";

    localparam logic [7:0][7:0] ATTR_CODE = {"9", "8", "7", "5", "4", "3", "2", "1"};

    localparam int NUM_ATTR   = 8;
    localparam int NUM_CSLOT  = 5;
    localparam int FG_BASE    = 1 + NUM_ATTR;
    localparam int BG_BASE    = FG_BASE + NUM_CSLOT;
    localparam int NUM_SLOTS  = BG_BASE + NUM_CSLOT;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);

    // one SGR parameter: up to three ASCII digits, dig[0] sent first
    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][7:0] dig;
    } param_t;

    typedef struct packed {
        logic [NUM_CSLOT-1:0]         live;
        param_t [NUM_CSLOT-1:0]       slot;
    } colour_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]         live;
        param_t [NUM_SLOTS-1:0]       slot;
    } seq_t;

    typedef enum logic [2:0] {
        PH_ESC,
        PH_BRK,
        PH_SEP,
        PH_DIG,
        PH_END
    } phase_t;

    function automatic param_t mk_param(input logic [1:0] len, input logic [7:0] d0,
                                        input logic [7:0] d1, input logic [7:0] d2);
        param_t p;
        p.len    = len;
        p.dig[0] = d0;
        p.dig[1] = d1;
        p.dig[2] = d2;
        return p;
    endfunction

    function automatic param_t dec_param(input logic [7:0] v);
        logic [1:0] hund;
        logic [6:0] rem;
        logic [3:0] tens;
        logic [3:0] units;
        logic [7:0] ch_h;
        logic [7:0] ch_t;
        logic [7:0] ch_u;
        param_t     p;
        if (v >= 8'd200) begin
            hund = 2'd2;
        end else if (v >= 8'd100) begin
            hund = 2'd1;
        end else begin
            hund = 2'd0;
        end
        rem  = 7'(v - 8'(hund) * 8'd100);
        tens = 4'd0;
        for (int t = 1; t < 10; t++) begin
            if (rem >= 7'(t * 10)) begin
                tens = 4'(t);
            end
        end
        units = 4'(rem - 7'(tens) * 7'd10);
        ch_h  = CH_ZERO + {6'd0, hund};
        ch_t  = CH_ZERO + {4'd0, tens};
        ch_u  = CH_ZERO + {4'd0, units};
        if (hund != 2'd0) begin
            p = mk_param(2'd3, ch_h, ch_t, ch_u);
        end else if (tens != 4'd0) begin
            p = mk_param(2'd2, ch_t, ch_u, CH_ZERO);
        end else begin
            p = mk_param(2'd1, ch_u, CH_ZERO, CH_ZERO);
        end
        return p;
    endfunction

    function automatic logic [1:0] norm_kind(input logic [1:0] k);
        logic [1:0] r;
        if (k == KIND_INDEX || k == KIND_RGB) begin
            r = k;
        end else begin
            r = KIND_DEFAULT;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sgr_style_sequence_encoder_core.sv -----
// Top level of the SGR style sequence encoder.
//
// Input channel (in_valid / in_stall) takes one style word per cycle while
// in_stall is low: attribute flags plus foreground and background colours.
// Output channel (out_valid / out_stall) sends the escape sequence one byte
// per word; last_byte marks the closing 'm'. A style yields 4 to 54 bytes.
// The first byte passes through the three front stages and the sequencer's
// state into the registered output word. Throughput: one byte per cycle
// while out_stall is low, with no gap between sequences when the next style
// is ready. Three front stages buffer styles meanwhile.
// ncv_mask is written over APB at address 0 and clears the attributes it selects
// whenever either colour is non-default; it is sampled as a style enters.
// Reset empties every stage and clears ncv_mask; stall holds the output word
// and backs up through the pipeline until in_stall rises.
`default_nettype none

module sgr_style_sequence_encoder_core
    import sgrenc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            attr_flags,
    input  wire logic [1:0]            fg_kind,
    input  wire logic [7:0]            fg_index,
    input  wire logic [7:0]            fg_red,
    input  wire logic [7:0]            fg_green,
    input  wire logic [7:0]            fg_blue,
    input  wire logic [1:0]            bg_kind,
    input  wire logic [7:0]            bg_index,
    input  wire logic [7:0]            bg_red,
    input  wire logic [7:0]            bg_green,
    input  wire logic [7:0]            bg_blue,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [7:0]            out_byte,
    output logic                       last_byte
);

    logic [7:0] ncv_mask;
    logic       seq_valid;
    logic       seq_take;
    seq_t       seq;

    sgrenc_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .ncv_mask (ncv_mask)
    );

    sgrenc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ncv_mask   (ncv_mask),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .attr_flags (attr_flags),
        .fg_kind    (fg_kind),
        .fg_index   (fg_index),
        .fg_red     (fg_red),
        .fg_green   (fg_green),
        .fg_blue    (fg_blue),
        .bg_kind    (bg_kind),
        .bg_index   (bg_index),
        .bg_red     (bg_red),
        .bg_green   (bg_green),
        .bg_blue    (bg_blue),
        .seq_valid  (seq_valid),
        .seq_take   (seq_take),
        .seq        (seq)
    );

    sgrenc_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .seq_valid (seq_valid),
        .seq_take  (seq_take),
        .seq       (seq),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/sgrenc_regs.sv -----
// APB register block holding the colour attribute suppression mask.
`default_nettype none

module sgrenc_regs
    import sgrenc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [7:0]            ncv_mask
);

    logic [7:0] ncv_mask_reg;
    logic [7:0] ncv_mask_next;
    logic       hit;

    assign pready = 1'b1;
    assign hit    = (paddr[APB_ADDR_W-1:2] == REG_NCV_MASK);

    always_comb
    begin
        ncv_mask_next = ncv_mask_reg;
        if (psel && penable && pwrite && pready && hit) begin
            ncv_mask_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ncv_mask_reg <= 8'd0;
        end else begin
            ncv_mask_reg <= ncv_mask_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit) begin
            prdata = {{(APB_DATA_W-8){1'b0}}, ncv_mask_reg};
        end
    end

    assign ncv_mask = ncv_mask_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sgrenc_front.sv -----
// Three-stage front pipeline: mask, decimal conversion, parameter slot build.
`default_nettype none

module sgrenc_front
    import sgrenc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] ncv_mask,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] attr_flags,
    input  wire logic [1:0] fg_kind,
    input  wire logic [7:0] fg_index,
    input  wire logic [7:0] fg_red,
    input  wire logic [7:0] fg_green,
    input  wire logic [7:0] fg_blue,
    input  wire logic [1:0] bg_kind,
    input  wire logic [7:0] bg_index,
    input  wire logic [7:0] bg_red,
    input  wire logic [7:0] bg_green,
    input  wire logic [7:0] bg_blue,
    output logic            seq_valid,
    input  wire logic       seq_take,
    output seq_t            seq
);

    // stage 1
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_attr_reg;
    logic [1:0] s1_fk_reg;
    logic [1:0] s1_bk_reg;
    logic [7:0] s1_fv_reg [4];
    logic [7:0] s1_bv_reg [4];
    // stage 2
    logic       s2_valid_reg;
    logic       s2_valid_next;
    logic [7:0] s2_attr_reg;
    logic [1:0] s2_fk_reg;
    logic [1:0] s2_bk_reg;
    logic [3:0] s2_fidx_reg;
    logic [3:0] s2_bidx_reg;
    logic       s2_fshort_reg;
    logic       s2_bshort_reg;
    param_t     s2_fd_reg [4];
    param_t     s2_bd_reg [4];
    // stage 3
    logic       s3_valid_reg;
    logic       s3_valid_next;
    seq_t       s3_seq_reg;
    seq_t       s3_seq_next;

    logic       rdy1;
    logic       rdy2;
    logic       rdy3;
    logic [1:0] fk_n;
    logic [1:0] bk_n;
    colour_t    fg_col;
    colour_t    bg_col;

    assign rdy3     = !s3_valid_reg || seq_take;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_stall = !rdy1;

    assign fk_n = norm_kind(fg_kind);
    assign bk_n = norm_kind(bg_kind);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        s3_valid_next = s3_valid_reg;
        if (rdy1) begin
            s1_valid_next = in_valid;
        end
        if (rdy2) begin
            s2_valid_next = s1_valid_reg;
        end
        if (rdy3) begin
            s3_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid) begin
            if (fk_n != KIND_DEFAULT || bk_n != KIND_DEFAULT) begin
                s1_attr_reg <= attr_flags & ~ncv_mask;
            end else begin
                s1_attr_reg <= attr_flags;
            end
            s1_fk_reg    <= fk_n;
            s1_bk_reg    <= bk_n;
            s1_fv_reg[0] <= fg_index;
            s1_fv_reg[1] <= fg_red;
            s1_fv_reg[2] <= fg_green;
            s1_fv_reg[3] <= fg_blue;
            s1_bv_reg[0] <= bg_index;
            s1_bv_reg[1] <= bg_red;
            s1_bv_reg[2] <= bg_green;
            s1_bv_reg[3] <= bg_blue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid_reg) begin
            s2_attr_reg   <= s1_attr_reg;
            s2_fk_reg     <= s1_fk_reg;
            s2_bk_reg     <= s1_bk_reg;
            s2_fidx_reg   <= s1_fv_reg[0][3:0];
            s2_bidx_reg   <= s1_bv_reg[0][3:0];
            s2_fshort_reg <= (s1_fv_reg[0] < 8'd16);
            s2_bshort_reg <= (s1_bv_reg[0] < 8'd16);
            for (int i = 0; i < 4; i++) begin
                s2_fd_reg[i] <= dec_param(s1_fv_reg[i]);
                s2_bd_reg[i] <= dec_param(s1_bv_reg[i]);
            end
        end
    end

    function automatic colour_t build_colour(input logic is_bg, input logic [1:0] kind,
                                             input logic is_short, input logic [3:0] idx,
                                             input param_t d_idx, input param_t d_r,
                                             input param_t d_g, input param_t d_b);
        colour_t    c;
        logic [7:0] lead;
        logic [7:0] digit;
        c     = '0;
        lead  = is_bg ? CH_BG_LEAD : CH_FG_LEAD;
        digit = CH_ZERO + {5'd0, idx[2:0]};
        case (kind)
            KIND_INDEX:
            begin
                if (is_short) begin
                    c.live[0] = 1'b1;
                    if (!idx[3]) begin
                        c.slot[0] = mk_param(2'd2, lead, digit, CH_ZERO);
                    end else if (is_bg) begin
                        c.slot[0] = mk_param(2'd3, CH_ONE, CH_ZERO, digit);
                    end else begin
                        c.slot[0] = mk_param(2'd2, CH_NINE, digit, CH_ZERO);
                    end
                end else begin
                    c.live    = 5'b00111;
                    c.slot[0] = mk_param(2'd2, lead, CH_EIGHT, CH_ZERO);
                    c.slot[1] = mk_param(2'd1, CH_FIVE, CH_ZERO, CH_ZERO);
                    c.slot[2] = d_idx;
                end
            end
            KIND_RGB:
            begin
                c.live    = 5'b11111;
                c.slot[0] = mk_param(2'd2, lead, CH_EIGHT, CH_ZERO);
                c.slot[1] = mk_param(2'd1, CH_TWO, CH_ZERO, CH_ZERO);
                c.slot[2] = d_r;
                c.slot[3] = d_g;
                c.slot[4] = d_b;
            end
            default:
            begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    always_comb
    begin
        fg_col = build_colour(1'b0, s2_fk_reg, s2_fshort_reg, s2_fidx_reg,
                              s2_fd_reg[0], s2_fd_reg[1], s2_fd_reg[2], s2_fd_reg[3]);
        bg_col = build_colour(1'b1, s2_bk_reg, s2_bshort_reg, s2_bidx_reg,
                              s2_bd_reg[0], s2_bd_reg[1], s2_bd_reg[2], s2_bd_reg[3]);
        s3_seq_next.live[0] = 1'b1;
        s3_seq_next.slot[0] = mk_param(2'd1, CH_ZERO, CH_ZERO, CH_ZERO);
        for (int i = 0; i < NUM_ATTR; i++) begin
            s3_seq_next.live[1+i] = s2_attr_reg[i];
            s3_seq_next.slot[1+i] = mk_param(2'd1, ATTR_CODE[i], CH_ZERO, CH_ZERO);
        end
        for (int i = 0; i < NUM_CSLOT; i++) begin
            s3_seq_next.live[FG_BASE+i] = fg_col.live[i];
            s3_seq_next.slot[FG_BASE+i] = fg_col.slot[i];
            s3_seq_next.live[BG_BASE+i] = bg_col.live[i];
            s3_seq_next.slot[BG_BASE+i] = bg_col.slot[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg) begin
            s3_seq_reg <= s3_seq_next;
        end
    end

    assign seq_valid = s3_valid_reg;
    assign seq       = s3_seq_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sgrenc_emit.sv -----
// Byte sequencer walking the parameter slots, with a registered output word.
`default_nettype none

module sgrenc_emit
    import sgrenc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       seq_valid,
    output logic            seq_take,
    input  wire seq_t       seq,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_byte
);

    logic              busy_reg;
    logic              busy_next;
    phase_t            phase_reg;
    phase_t            phase_next;
    seq_t              seq_reg;
    seq_t              seq_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic [1:0]        dig_reg;
    logic [1:0]        dig_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    logic              out_ready;
    logic              adv;
    logic              load;
    param_t            cur;
    logic              slot_done;
    logic [NUM_SLOTS-1:0] rest;
    logic [SLOT_W-1:0] nidx;
    logic              any_rest;
    logic [7:0]        byte_cur;
    logic              last_cur;

    assign out_ready = !out_valid_reg || !out_stall;
    assign adv       = busy_reg && out_ready;
    assign load      = seq_valid && (!busy_reg || (adv && phase_reg == PH_END));
    assign seq_take  = load;

    assign cur       = seq_reg.slot[idx_reg];
    assign slot_done = (dig_reg == cur.len - 2'd1);
    assign rest      = seq_reg.live & ~(NUM_SLOTS'(1) << idx_reg);
    assign any_rest  = |rest;

    always_comb
    begin
        nidx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (rest[i]) begin
                nidx = SLOT_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        seq_next   = seq_reg;
        idx_next   = idx_reg;
        dig_next   = dig_reg;
        if (adv) begin
            case (phase_reg)
                PH_ESC:
                begin
                    phase_next = PH_BRK;
                end
                PH_BRK:
                begin
                    phase_next = PH_DIG;
                    idx_next   = '0;
                    dig_next   = 2'd0;
                end
                PH_DIG:
                begin
                    if (!slot_done) begin
                        dig_next = dig_reg + 2'd1;
                    end else begin
                        seq_next.live = rest;
                        if (any_rest) begin
                            phase_next = PH_SEP;
                            idx_next   = nidx;
                        end else begin
                            phase_next = PH_END;
                        end
                    end
                end
                PH_SEP:
                begin
                    phase_next = PH_DIG;
                    dig_next   = 2'd0;
                end
                PH_END:
                begin
                    busy_next = 1'b0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        if (load) begin
            busy_next  = 1'b1;
            phase_next = PH_ESC;
            seq_next   = seq;
            idx_next   = '0;
            dig_next   = 2'd0;
        end
    end

    // outputs
    always_comb
    begin
        last_cur = 1'b0;
        case (phase_reg)
            PH_ESC:
            begin
                byte_cur = CH_ESC;
            end
            PH_BRK:
            begin
                byte_cur = CH_BRK;
            end
            PH_SEP:
            begin
                byte_cur = CH_SEP;
            end
            PH_DIG:
            begin
                byte_cur = cur.dig[dig_reg];
            end
            PH_END:
            begin
                byte_cur = CH_END;
                last_cur = 1'b1;
            end
            default:
            begin
                byte_cur = CH_END;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_ESC;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        idx_reg <= idx_next;
        dig_reg <= dig_next;
        if (adv) begin
            out_byte_reg <= byte_cur;
            out_last_reg <= last_cur;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = out_last_reg;

endmodule

`default_nettype wire
